### design/gbc_pkg.sv
// Shared types and constants for the 3x3 binomial blur block.
package gbc_pkg;

   localparam int FRAME_WIDTH_BITS  = 11;
   localparam int FRAME_HEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int KERNEL_SHIFT      = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_DRAIN,
      OP_PRIME
   } op_kind_type;

   typedef enum logic [1:0] {
      LEFT_N0,
      LEFT_N1,
      LEFT_N2
   } left_sel_type;

   typedef struct packed {
      op_kind_type  kind;
      logic         first_row;
      logic         top_from_mid;
      left_sel_type left_sel;
      logic         center_n2;
      logic [1:0]   nres;
      logic         last0;
      logic         eof0;
   } b_ctrl_type;

endpackage

### design/gaussian_blur_3x3_clamped.sv
// Streaming 3x3 binomial blur (1 2 1 / 2 4 2 / 1 2 1) with edge clamping, two line RAMs.
//
// Input channel req_: one transaction per item. req_tuser is the command (0 = pixel,
// 1 = drain step), req_tdata carries the gray value in raster order. Result channel
// rsp_: rsp_tdata is the blurred value, rsp_tlast marks the final result of an input
// item, rsp_tuser marks the result for the frame's last pixel.
// Each result for pixel (r,c) leaves when pixel (r+1,c+1) is taken; a row's last pixel
// yields two results. After the frame's last pixel the host sends frame_width drain
// items, each giving one result of the bottom row.
// A result reaches rsp_ through the window stage and the output register: the RAM read
// and window stage load on the transaction's edge, and the output register then takes the result once it has room.
// Throughput: one item per clock while rsp_tready is high. The two-slot output register takes
// one item's results at a time, so an item with results right after a row's last pixel waits
// until a slot is free; a priming read of column 0 runs after the frame's last pixel, during which
// req_tready is low. When rsp_tready is low the result stays registered, and one more
// item is taken into the read stage before req_tready drops.
// Reset (synchronous): frame_width and frame_height return to 1, counters to zero and
// the pipeline empties; the line RAMs are not cleared and need no clearing pass.
// A csr_ write restarts the frame; write only while the block is idle.
module gaussian_blur_3x3_clamped #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel_in
   input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] req_tdata,
   // cmd
   input  logic [0:0]                           req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pixel_out
   output logic [((PIXEL_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   output logic                                 rsp_tlast,
   // end_of_frame
   output logic [0:0]                           rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_wr_en,
   input  logic [gbc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gbc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import gbc_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int DB = ((PIXEL_BITS + 7) / 8) * 8;

   typedef logic [3*PIXEL_BITS-1:0] column_type;

   // configuration
   logic [FRAME_WIDTH_BITS-1:0]  width_ff, width_in;
   logic [FRAME_HEIGHT_BITS-1:0] height_ff, height_in;
   logic [WW-1:0]                w_eff;
   logic [FRAME_HEIGHT_BITS-1:0] h_eff;

   // address stage
   logic [CW-1:0]                col_ff, col_in;
   logic [FRAME_HEIGHT_BITS-1:0] row_ff, row_in;
   logic [WW-1:0]                drain_ff, drain_in;
   logic                         primed_ff, primed_in;
   logic                         req_fire, a_free, drain_phase, prime_pending;
   logic                         pix_ok, drn_ok, prime_go, issue, final_col;
   logic [WW-1:0]                col_w, col_next, drain_next;
   logic [CW-1:0]                a_addr;
   b_ctrl_type                   a_ctrl;
   logic [PIXEL_BITS-1:0]        req_px;

   // window stage
   logic                         b_valid_ff, b_valid_in;
   b_ctrl_type                   b_ctrl_ff;
   logic [CW-1:0]                b_addr_ff;
   logic [PIXEL_BITS-1:0]        b_px_ff;
   logic                         b_adv, b_is_pix, b_use_px;
   logic                         fw_lo_hit_ff, fw_lo_hit_in, fw_up_hit_ff, fw_up_hit_in;
   logic [PIXEL_BITS-1:0]        fw_lo_data_ff, fw_up_data_ff;
   logic [PIXEL_BITS-1:0]        lo_rd, up_rd, lo_q, up_q;
   logic [PIXEL_BITS-1:0]        col_top, col_mid, col_bot;
   logic                         lo_we, up_we;
   column_type                   win_ff [2];
   column_type                   n0, n1, n2, left_col, center_col;
   logic [PIXEL_BITS-1:0]        res0_px, res1_px;

   // output register, two slots
   logic [1:0]                   out_cnt_ff, out_cnt_in;
   logic [PIXEL_BITS-1:0]        s0_px_ff, s0_px_in, s1_px_ff, s1_px_in;
   logic                         s0_last_ff, s0_last_in, s0_eof_ff, s0_eof_in;
   logic                         out_take, rsp_fire;

   function automatic logic [PIXEL_BITS+1:0] col_sum(input column_type col);
      col_sum = (PIXEL_BITS+2)'(col[PIXEL_BITS-1:0])
              + ((PIXEL_BITS+2)'(col[2*PIXEL_BITS-1:PIXEL_BITS]) << 1)
              + (PIXEL_BITS+2)'(col[3*PIXEL_BITS-1:2*PIXEL_BITS]);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] blur(input column_type l, input column_type c,
                                                   input column_type r);
      logic [PIXEL_BITS+3:0] sum;
      sum = (PIXEL_BITS+4)'(col_sum(l)) + ((PIXEL_BITS+4)'(col_sum(c)) << 1)
          + (PIXEL_BITS+4)'(col_sum(r));
      return sum[PIXEL_BITS+KERNEL_SHIFT-1:KERNEL_SHIFT];
   endfunction

   // clamp the frame size registers
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      h_eff = (height_ff == '0) ? FRAME_HEIGHT_BITS'(1) : height_ff;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata[FRAME_WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: height_in = csr_wdata[FRAME_HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // address stage: classify the item, pick the line RAM address
   assign req_px        = req_tdata[PIXEL_BITS-1:0];
   assign a_free        = !b_valid_ff || b_adv;
   assign drain_phase   = (row_ff == h_eff);
   assign prime_pending = drain_phase && !primed_ff;
   assign req_tready    = a_free && !prime_pending;
   assign req_fire      = req_tvalid && req_tready;
   assign col_w         = WW'(col_ff);
   assign col_next      = col_w + WW'(1);
   assign final_col     = (col_next == w_eff);
   assign drain_next    = drain_ff + WW'(1);
   assign pix_ok        = (req_tuser[0] == CMD_PIXEL) && (row_ff < h_eff) && (col_w < w_eff);
   assign drn_ok        = (req_tuser[0] == CMD_DRAIN) && drain_phase && primed_ff
                          && (drain_ff < w_eff);
   assign prime_go      = prime_pending && a_free;
   assign issue         = (req_fire && (pix_ok || drn_ok)) || prime_go;

   always_comb begin
      a_ctrl              = '0;
      a_ctrl.kind         = OP_PRIME;
      a_ctrl.top_from_mid = (h_eff < FRAME_HEIGHT_BITS'(2));
      a_ctrl.left_sel     = LEFT_N1;
      a_addr              = '0;
      if (prime_go) begin
         a_ctrl.kind = OP_PRIME;
      end else if (drn_ok) begin
         a_ctrl.kind     = OP_DRAIN;
         a_ctrl.left_sel = (drain_ff == '0) ? LEFT_N1 : LEFT_N0;
         a_ctrl.nres     = 2'd1;
         a_ctrl.last0    = 1'b1;
         a_ctrl.eof0     = (drain_next == w_eff);
         // clamp the right neighbor to the last column
         a_addr = (drain_next >= w_eff) ? CW'(w_eff - WW'(1)) : CW'(drain_next);
      end else begin
         a_ctrl.kind         = OP_PIXEL;
         a_ctrl.first_row    = (row_ff == '0);
         a_ctrl.top_from_mid = (row_ff == FRAME_HEIGHT_BITS'(1));
         a_addr              = col_ff;
         if (row_ff != '0) begin
            if (w_eff == WW'(1)) begin
               a_ctrl.left_sel  = LEFT_N2;
               a_ctrl.center_n2 = 1'b1;
               a_ctrl.nres      = 2'd1;
               a_ctrl.last0     = 1'b1;
            end else if (col_ff != '0) begin
               a_ctrl.left_sel = (col_ff == CW'(1)) ? LEFT_N1 : LEFT_N0;
               a_ctrl.nres     = final_col ? 2'd2 : 2'd1;
               a_ctrl.last0    = !final_col;
            end
         end
      end
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      drain_in  = drain_ff;
      primed_in = primed_ff;
      if (csr_wr_en) begin
         col_in    = '0;
         row_in    = '0;
         drain_in  = '0;
         primed_in = 1'b0;
      end else if (prime_go) begin
         primed_in = 1'b1;
      end else if (req_fire && pix_ok) begin
         if (final_col) begin
            col_in   = '0;
            row_in   = row_ff + FRAME_HEIGHT_BITS'(1);
            drain_in = '0;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end else if (req_fire && drn_ok) begin
         drain_in = drain_next;
         // frame done: restart
         if (drain_next == w_eff) begin
            col_in    = '0;
            row_in    = '0;
            drain_in  = '0;
            primed_in = 1'b0;
         end
      end
   end

   // window stage: merge RAM data with forwarded writes, shift the window, form results
   assign b_adv    = b_valid_ff && ((b_ctrl_ff.nres == 2'd0) || out_take);
   assign b_is_pix = (b_ctrl_ff.kind == OP_PIXEL);
   assign b_use_px = b_is_pix && b_ctrl_ff.first_row;
   assign lo_q     = fw_lo_hit_ff ? fw_lo_data_ff : lo_rd;
   assign up_q     = fw_up_hit_ff ? fw_up_data_ff : up_rd;
   assign col_bot  = b_is_pix ? b_px_ff : lo_q;
   assign col_mid  = b_use_px ? b_px_ff : lo_q;
   assign col_top  = b_use_px ? b_px_ff : (b_ctrl_ff.top_from_mid ? lo_q : up_q);
   assign lo_we    = b_adv && b_is_pix;
   assign up_we    = lo_we && !b_ctrl_ff.first_row;

   assign b_valid_in   = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
   assign fw_lo_hit_in = issue ? (lo_we && (b_addr_ff == a_addr)) : fw_lo_hit_ff;
   assign fw_up_hit_in = issue ? (up_we && (b_addr_ff == a_addr)) : fw_up_hit_ff;

   assign n0 = win_ff[0];
   assign n1 = win_ff[1];
   assign n2 = {col_bot, col_mid, col_top};

   always_comb begin
      unique case (b_ctrl_ff.left_sel)
         LEFT_N0: left_col = n0;
         LEFT_N1: left_col = n1;
         LEFT_N2: left_col = n2;
         default: left_col = n1;
      endcase
      center_col = b_ctrl_ff.center_n2 ? n2 : n1;
   end

   assign res0_px = blur(left_col, center_col, n2);
   assign res1_px = blur(n1, n2, n2);

   gbc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_lower (
      .clock   (clock),
      .wr_en   (lo_we),
      .wr_addr (b_addr_ff),
      .wr_data (b_px_ff),
      .rd_en   (issue),
      .rd_addr (a_addr),
      .rd_data (lo_rd)
   );

   gbc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (up_we),
      .wr_addr (b_addr_ff),
      .wr_data (lo_q),
      .rd_en   (issue),
      .rd_addr (a_addr),
      .rd_data (up_rd)
   );

   // output register
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign out_take = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_tready);

   always_comb begin
      out_cnt_in = out_cnt_ff;
      s0_px_in   = s0_px_ff;
      s0_last_in = s0_last_ff;
      s0_eof_in  = s0_eof_ff;
      s1_px_in   = s1_px_ff;
      if (b_adv && (b_ctrl_ff.nres != 2'd0)) begin
         out_cnt_in = b_ctrl_ff.nres;
         s0_px_in   = res0_px;
         s0_last_in = b_ctrl_ff.last0;
         s0_eof_in  = b_ctrl_ff.eof0;
         s1_px_in   = res1_px;
      end else if (rsp_fire) begin
         // advance the second slot, always the closing result of a row
         out_cnt_in = out_cnt_ff - 2'd1;
         s0_px_in   = s1_px_ff;
         s0_last_in = 1'b1;
         s0_eof_in  = 1'b0;
      end
   end

   assign rsp_tvalid   = (out_cnt_ff != 2'd0);
   assign rsp_tdata    = DB'(s0_px_ff);
   assign rsp_tlast    = s0_last_ff;
   assign rsp_tuser[0] = s0_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FRAME_WIDTH_BITS'(1);
         height_ff    <= FRAME_HEIGHT_BITS'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= '0;
         primed_ff    <= 1'b0;
         b_valid_ff   <= 1'b0;
         fw_lo_hit_ff <= 1'b0;
         fw_up_hit_ff <= 1'b0;
         out_cnt_ff   <= 2'd0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_ff     <= drain_in;
         primed_ff    <= primed_in;
         b_valid_ff   <= b_valid_in;
         fw_lo_hit_ff <= fw_lo_hit_in;
         fw_up_hit_ff <= fw_up_hit_in;
         out_cnt_ff   <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_ctrl_ff     <= a_ctrl;
         b_addr_ff     <= a_addr;
         b_px_ff       <= req_px;
         fw_lo_data_ff <= b_px_ff;
         fw_up_data_ff <= lo_q;
      end
      if (b_adv) begin
         win_ff[0] <= n1;
         win_ff[1] <= n2;
      end
      s0_px_ff   <= s0_px_in;
      s0_last_ff <= s0_last_in;
      s0_eof_ff  <= s0_eof_in;
      s1_px_ff   <= s1_px_in;
   end

`ifndef NO_ASSERTIONS
   a_out_cnt_range : assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output register holds more than two results");

   a_drain_bound : assert property (@(posedge clock) disable iff (reset)
      drain_ff < w_eff || drain_ff == '0)
      else $error("drain count ran past the frame width");

   a_stall_has_cause : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !b_adv) |-> (out_cnt_ff != 2'd0))
      else $error("window stage stalled with an empty output register");

   a_prime_blocks_input : assert property (@(posedge clock) disable iff (reset)
      $rose(primed_ff) |-> $past(!req_tready))
      else $error("input accepted during the priming read");
`endif

endmodule

### design/gbc_ram.sv
// Generic simple dual-port RAM with registered read (old data on collision).
module gbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/gaussian_blur_3x3_clamped_test.sv
// Self-checking testbench for the streaming 3x3 binomial blur with edge clamping.
module gaussian_blur_3x3_clamped_test;
   import gbc_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 900;

   typedef struct packed {
      logic [7:0] pixel;
      logic       last;
      logic       eof;
   } blur_result_type;

   // Tracks frame position, line stores and window; predicts every blurred pixel.
   class blur_scoreboard_type;
      logic [10:0]  width_reg;
      logic [15:0]  height_reg;
      logic [7:0]   upper_row [MAX_WIDTH];
      logic [7:0]   lower_row [MAX_WIDTH];
      logic [7:0]   win [3][3];   // [column][top, mid, bottom]
      int unsigned  col_pos;
      int unsigned  row_pos;
      int unsigned  drain_pos;
      blur_result_type expected_q [$];
      int           errors;

      function new();
         width_reg  = 11'd1;
         height_reg = 16'd1;
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         col_pos   = 0;
         row_pos   = 0;
         drain_pos = 0;
         errors    = 0;
      endfunction

      function int unsigned eff_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned eff_height();
         return (height_reg == 0) ? 1 : height_reg;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [7:0] weigh(int unsigned left_sum, int unsigned mid_sum,
                                 int unsigned right_sum);
         int unsigned total;
         total = (left_sum + 2 * mid_sum + right_sum) >> 4;
         return total[7:0];
      endfunction

      function void queue_result(logic [7:0] pixel, logic last, logic eof);
         expected_q.push_back({pixel, last, eof});
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [15:0] value);
         if (index == CSR_FRAME_WIDTH) width_reg = value[10:0];
         else height_reg = value;
         // any write restarts the frame
         col_pos   = 0;
         row_pos   = 0;
         drain_pos = 0;
      endfunction

      // Returns 1 when the transaction takes effect, 0 when the block ignores it.
      function bit note_input(logic cmd, logic [7:0] px);
         int unsigned w;
         int unsigned h;
         int unsigned x;
         int unsigned sums [3];
         int          k;
         logic [7:0]  top;
         logic [7:0]  mid;
         bit          final_col;
         w = eff_width();
         h = eff_height();
         if (cmd == CMD_DRAIN) begin
            if (row_pos != h || drain_pos >= w) return 0;
            for (k = 0; k < 3; k++) begin
               if (k == 0) x = (drain_pos == 0) ? 0 : drain_pos - 1;
               else if (k == 1) x = drain_pos;
               else x = (drain_pos + 1 >= w) ? w - 1 : drain_pos + 1;
               // bottom row repeats itself below the frame
               sums[k] = 3 * lower_row[x] + ((h >= 2) ? upper_row[x] : lower_row[x]);
            end
            drain_pos++;
            queue_result(weigh(sums[0], sums[1], sums[2]), 1'b1, drain_pos == w);
            if (drain_pos == w) begin
               col_pos   = 0;
               row_pos   = 0;
               drain_pos = 0;
            end
            return 1;
         end
         if (row_pos >= h || col_pos >= w) return 0;
         if (row_pos >= 1) begin
            mid = lower_row[col_pos];
            top = (row_pos == 1) ? mid : upper_row[col_pos];
            upper_row[col_pos] = mid;
         end else begin
            top = px;
            mid = px;
         end
         lower_row[col_pos] = px;
         for (k = 0; k < 3; k++) begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
         end
         win[2][0] = top;
         win[2][1] = mid;
         win[2][2] = px;
         for (k = 0; k < 3; k++) sums[k] = win[k][0] + 2 * win[k][1] + win[k][2];
         final_col = (col_pos + 1 == w);
         if (row_pos >= 1) begin
            if (w == 1) begin
               queue_result(weigh(sums[2], sums[2], sums[2]), 1'b1, 1'b0);
            end else if (col_pos >= 1) begin
               // column 1 clamps its left neighbor to column 0
               queue_result(weigh((col_pos == 1) ? sums[1] : sums[0], sums[1], sums[2]),
                            !final_col, 1'b0);
               if (final_col) queue_result(weigh(sums[1], sums[2], sums[2]), 1'b1, 1'b0);
            end
         end
         if (final_col) begin
            col_pos   = 0;
            row_pos++;
            drain_pos = 0;
         end else begin
            col_pos++;
         end
         return 1;
      endfunction

      function void check_result(logic [7:0] pixel, logic last, logic eof);
         blur_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: pixel_out %0d last_in_run %0b end_of_frame %0b",
                   pixel, last, eof);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (pixel !== want.pixel) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel, pixel);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_in_run: expected %0b, actual %0b", want.last, last);
            errors++;
         end
         if (eof !== want.eof) begin
            $error("end_of_frame: expected %0b, actual %0b", want.eof, eof);
            errors++;
         end
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic [7:0]                req_tdata  = '0;
   logic [0:0]                req_tuser  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   logic [0:0]                rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_wr_en  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   blur_scoreboard_type board;
   bit             steady = 1'b0;
   int unsigned    useful_items = 0;

   gaussian_blur_3x3_clamped dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Entered and left at a falling edge; valid stays high across back-to-back items.
   task automatic push_item(logic cmd, logic [7:0] px);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (board.note_input(cmd, px)) useful_items++;
      @(negedge clock);
   endtask

   // Hold the input until every expected result is out, then let the pipeline empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      board.write_reg(index, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [15:0] width_word, logic [15:0] height_word);
      settle();
      write_csr(CSR_FRAME_WIDTH, width_word);
      write_csr(CSR_FRAME_HEIGHT, height_word);
   endtask

   // Send rows_sent rows of pixels; drain only when the frame is complete.
   task automatic stream_frame(int unsigned w, int unsigned h, int unsigned rows_sent,
                               bit noisy);
      int unsigned r;
      int unsigned c;
      for (r = 0; r < rows_sent; r++) begin
         for (c = 0; c < w; c++) begin
            if (noisy && $urandom_range(0, 15) == 0) push_item(CMD_DRAIN, rand_pixel());
            push_item(CMD_PIXEL, rand_pixel());
         end
      end
      if (rows_sent == h) begin
         if (noisy && $urandom_range(0, 3) == 0) push_item(CMD_PIXEL, rand_pixel());
         repeat (w) push_item(CMD_DRAIN, rand_pixel());
         if (noisy && $urandom_range(0, 3) == 0) push_item(CMD_DRAIN, rand_pixel());
      end
   endtask

   initial begin
      int          stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser[0]);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned rows;
      logic [15:0] width_word;
      board = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry is one pixel; a stray drain and a surplus pixel are dropped
      push_item(CMD_DRAIN, 8'hA5);
      push_item(CMD_PIXEL, 8'hFF);
      push_item(CMD_PIXEL, 8'h00);
      push_item(CMD_DRAIN, 8'h5A);
      // zero sizes fall back to one
      configure(16'h0000, 16'h0000);
      stream_frame(1, 1, 1, 1'b0);
      // unused upper width bits are ignored
      configure(16'hF803, 16'd2);
      stream_frame(3, 2, 2, 1'b0);
      configure(16'd1, 16'd3);
      stream_frame(1, 3, 3, 1'b0);
      configure(16'd4, 16'd1);
      stream_frame(4, 1, 1, 1'b0);
      // oversize width clamps to the line store depth: a short first row gives no result
      configure(16'h07FF, 16'd2);
      repeat (24) push_item(CMD_PIXEL, rand_pixel());
      // tallest frame, abandoned part way; the next write restarts it
      configure(16'd5, 16'hFFFF);
      stream_frame(5, 65535, 3, 1'b1);

      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: w = 1;
            1: w = 2;
            2, 3, 4, 5, 6: w = $urandom_range(3, 10);
            7, 8: w = $urandom_range(11, 40);
            default: w = $urandom_range(41, 120);
         endcase
         h = $urandom_range(1, 6);
         width_word = 16'(w);
         if ($urandom_range(0, 3) == 0) width_word[15:11] = 5'($urandom_range(0, 31));
         configure(width_word, 16'(h));
         steady = ($urandom_range(0, 4) == 0);
         rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, h - 1) : h;
         stream_frame(w, h, rows, 1'b1);
      end
      steady = 1'b0;

      settle();
      if (board.errors == 0) begin
         $display("gaussian_blur_3x3_clamped regression: pass");
      end else begin
         $display("gaussian_blur_3x3_clamped regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("gaussian_blur_3x3_clamped regression: fail");
      $finish;
   end

endmodule

### filelist.f
design/gbc_pkg.sv
design/gbc_ram.sv
design/gaussian_blur_3x3_clamped.sv
tb/gaussian_blur_3x3_clamped_test.sv
